// ----- rtl/timed_event_list_assert.svh -----
// ----------------------------------------------------------------------------
// Timed event list assertion macros
// Shared clocking and reset wrapping for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TIMED_EVENT_LIST_ASSERT_SVH
`define TIMED_EVENT_LIST_ASSERT_SVH

// condition holds at every edge out of reset
`define TEL_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define TEL_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TEL_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tel_pkg.sv -----
// ----------------------------------------------------------------------------
// Timed event list package
// Field widths, command and status codes, slot record layout.
// ----------------------------------------------------------------------------
package tel_pkg;

	localparam int TIME_W   = 32;
	localparam int TARGET_W = 16;
	localparam int TAG_W    = 32;
	localparam int HANDLE_W = 4;

	typedef enum logic [1:0] {
		OP_REQUEST = 2'd0,
		OP_CANCEL  = 2'd1,
		OP_PROCESS = 2'd2,
		OP_NOP     = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_QUEUED      = 3'd0,
		ST_FULL        = 3'd1,
		ST_CANCELLED   = 3'd2,
		ST_NOT_FOUND   = 3'd3,
		ST_FIRED       = 3'd4,
		ST_NOTHING_DUE = 3'd5
	} status_t;

	// one timer entry as held in the slot RAM
	typedef struct packed {
		logic [TARGET_W-1:0] target;
		logic [TAG_W-1:0]    tag;
		logic [TIME_W-1:0]   start;
		logic [TIME_W-1:0]   lim;
	} slot_rec_t;

endpackage

// ----- rtl/tel_ram.sv -----
// ----------------------------------------------------------------------------
// Timed event list RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/tel_due.sv -----
// ----------------------------------------------------------------------------
// Timed event list due check
// Shared elapsed-time unit: registers now - start, then signed compare.
// ----------------------------------------------------------------------------
module tel_due (
	input  logic                      clk,
	input  logic                      ld,
	input  logic [tel_pkg::TIME_W-1:0] now,
	input  logic [tel_pkg::TIME_W-1:0] start,
	input  logic [tel_pkg::TIME_W-1:0] lim,
	output logic                      due
);

	import tel_pkg::*;

	logic [TIME_W-1:0] diff_q;
	logic [TIME_W-1:0] lim_q;

	// subtract into a register, compare the registered values in the next cycle
	always_ff @(posedge clk) begin
		if (ld) begin
			diff_q <= now - start;
			lim_q  <= lim;
		end
	end

	assign due = $signed(diff_q) > $signed(lim_q);

endmodule

// ----- rtl/timed_event_list.sv -----
// ----------------------------------------------------------------------------
// Timed event list
// Table of one-shot timers kept in insertion order: request, cancel, process.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; busy then stays
// high until the command's last result word has been issued. Result words come
// out on status/slot/out_target/out_tag/last, each valid for exactly one cycle
// while done is high; the receiver cannot hold them off, so it must take every
// done cycle. last marks the final word of a command. A request scans the valid
// bits for the lowest free slot one slot per cycle and reports full after the
// last slot. A cancel walks the order list through the order RAM's single read
// port, one pending entry at a time. A process walks the same list and runs
// each pending entry through the shared subtract/compare unit: order RAM read,
// slot RAM read, subtract, compare. Fired words come out during the walk, one
// behind, so the final one can carry last; the closing word leaves on the last
// cycle. Opcode three is taken and dropped with no result. The RAMs are not
// reset; since the valid bits and the count are, they need no clearing pass.
// ----------------------------------------------------------------------------
`include "timed_event_list_assert.svh"

module timed_event_list #(
	parameter int SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    opcode,
	input  logic [tel_pkg::TIME_W-1:0]    now_ms,
	input  logic [tel_pkg::TARGET_W-1:0]  target,
	input  logic [tel_pkg::TAG_W-1:0]     event_tag,
	input  logic [tel_pkg::TIME_W-1:0]    wait_ms,
	input  logic [tel_pkg::HANDLE_W-1:0]  handle_slot,
	output logic                          done,
	output logic [2:0]                    status,
	output logic [tel_pkg::HANDLE_W-1:0]  slot,
	output logic [tel_pkg::TARGET_W-1:0]  out_target,
	output logic [tel_pkg::TAG_W-1:0]     out_tag,
	output logic                          last
);

	import tel_pkg::*;

	// slot index, count and compare widths
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int IW = (SW > HANDLE_W) ? SW : HANDLE_W;
	localparam int RW = $bits(slot_rec_t);

	typedef enum logic [2:0] {
		S_IDLE,  // waiting for a command
		S_SCAN,  // request: look for a free slot
		S_ORD,   // walk: read order list entry
		S_ENT,   // walk: entry available
		S_DIF,   // process: slot record available, subtract
		S_CMP,   // process: compare and fire or keep
		S_FIN    // closing word and count update
	} state_t;

	state_t               state_q;
	opcode_t              op_q;
	logic [TIME_W-1:0]    now_q;
	logic [TARGET_W-1:0]  target_q;
	logic [TAG_W-1:0]     tag_q;
	logic [TIME_W-1:0]    wait_q;
	logic [HANDLE_W-1:0]  hdl_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        keep_q;
	logic [CW-1:0]        count_q;
	logic                 found_q;
	logic [SW-1:0]        ent_q;
	logic [SLOTS-1:0]     valid_q;

	// fired word held back one so the final one can be marked
	logic                 pend_q;
	logic [SW-1:0]        pend_slot_q;
	logic [TARGET_W-1:0]  pend_target_q;
	logic [TAG_W-1:0]     pend_tag_q;

	logic                 done_q;
	status_t              status_q;
	logic [HANDLE_W-1:0]  slot_q;
	logic [TARGET_W-1:0]  out_target_q;
	logic [TAG_W-1:0]     out_tag_q;
	logic                 last_q;

	// RAM ports
	logic                 ord_we, ord_re;
	logic [SW-1:0]        ord_waddr, ord_wdata, ord_rdata;
	logic                 slot_we, slot_re;
	slot_rec_t            slot_wdata, slot_rdata;
	logic [RW-1:0]        slot_rdata_raw;
	logic                 due_ld, due;

	logic [SW-1:0]        idx_a;
	logic [IW-1:0]        hdl_w;
	logic [IW-1:0]        ent_w;
	logic                 accept;
	logic                 idx_end;
	logic                 count_ok;

	assign idx_a   = idx_q[SW-1:0];
	assign hdl_w   = IW'(hdl_q);
	assign ent_w   = IW'(ord_rdata);
	assign accept  = start && !busy;
	assign idx_end = (CW'(idx_q + 1'b1) == count_q);
	assign slot_rdata = slot_rec_t'(slot_rdata_raw);

	// order list: slot numbers in insertion order, first count_q meaningful
	tel_ram #(
		.WIDTH (SW),
		.DEPTH (SLOTS)
	) u_order_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.re    (ord_re),
		.raddr (idx_a),
		.rdata (ord_rdata)
	);

	// timer records, indexed by slot
	tel_ram #(
		.WIDTH (RW),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (idx_a),
		.wdata (RW'(slot_wdata)),
		.re    (slot_re),
		.raddr (ord_rdata),
		.rdata (slot_rdata_raw)
	);

	tel_due u_due (
		.clk   (clk),
		.ld    (due_ld),
		.now   (now_q),
		.start (slot_rdata.start),
		.lim   (slot_rdata.lim),
		.due   (due)
	);

	// RAM and due-unit control
	always_comb begin
		ord_we     = 1'b0;
		ord_waddr  = idx_a;
		ord_wdata  = ord_rdata;
		ord_re     = 1'b0;
		slot_we    = 1'b0;
		slot_re    = 1'b0;
		slot_wdata = '{target: target_q, tag: tag_q, start: now_q, lim: wait_q};
		due_ld     = 1'b0;
		unique case (state_q)
			S_SCAN: begin
				// claim free slot and append it to the order list
				if (!valid_q[idx_a]) begin
					slot_we   = 1'b1;
					ord_we    = 1'b1;
					ord_waddr = count_q[SW-1:0];
					ord_wdata = idx_a;
				end
			end
			S_ORD: begin
				ord_re = 1'b1;
			end
			S_ENT: begin
				if (op_q == OP_CANCEL) begin
					// past the match: close the gap by one
					if (found_q) begin
						ord_we    = 1'b1;
						ord_waddr = idx_a - SW'(1);
						ord_wdata = ord_rdata;
					end
				end else begin
					slot_re = 1'b1;
				end
			end
			S_DIF: begin
				due_ld = 1'b1;
			end
			S_CMP: begin
				// not due: compact into the keep position
				if (!(valid_q[ent_q] && due)) begin
					ord_we    = 1'b1;
					ord_waddr = keep_q[SW-1:0];
					ord_wdata = ent_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_NOP;
			now_q         <= '0;
			target_q      <= '0;
			tag_q         <= '0;
			wait_q        <= '0;
			hdl_q         <= '0;
			idx_q         <= '0;
			keep_q        <= '0;
			count_q       <= '0;
			found_q       <= 1'b0;
			ent_q         <= '0;
			valid_q       <= '0;
			pend_q        <= 1'b0;
			pend_slot_q   <= '0;
			pend_target_q <= '0;
			pend_tag_q    <= '0;
			done_q        <= 1'b0;
			status_q      <= ST_QUEUED;
			slot_q        <= '0;
			out_target_q  <= '0;
			out_tag_q     <= '0;
			last_q        <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (accept) begin
						op_q     <= opcode_t'(opcode);
						now_q    <= now_ms;
						target_q <= target;
						tag_q    <= event_tag;
						wait_q   <= wait_ms;
						hdl_q    <= handle_slot;
						idx_q    <= '0;
						keep_q   <= '0;
						found_q  <= 1'b0;
						pend_q   <= 1'b0;
						unique case (opcode_t'(opcode)) inside
							OP_REQUEST: state_q <= S_SCAN;
							OP_CANCEL, OP_PROCESS: begin
								state_q <= (count_q == '0) ? S_FIN : S_ORD;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					// a word leaves on a claim or on the last slot when full
					done_q <= !valid_q[idx_a] || (idx_q == CW'(SLOTS - 1));
					if (!valid_q[idx_a]) begin
						valid_q[idx_a] <= 1'b1;
						count_q        <= CW'(count_q + 1'b1);
						status_q       <= ST_QUEUED;
						slot_q         <= HANDLE_W'(IW'(idx_a));
						out_target_q   <= '0;
						out_tag_q      <= '0;
						last_q         <= 1'b1;
						state_q        <= S_IDLE;
					end else if (idx_q == CW'(SLOTS - 1)) begin
						status_q     <= ST_FULL;
						slot_q       <= '0;
						out_target_q <= '0;
						out_tag_q    <= '0;
						last_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						idx_q <= CW'(idx_q + 1'b1);
					end
				end
				S_ORD: begin
					done_q  <= 1'b0;
					state_q <= S_ENT;
				end
				S_ENT: begin
					done_q <= 1'b0;
					if (op_q == OP_CANCEL) begin
						if (!found_q && ent_w == hdl_w) begin
							found_q <= 1'b1;
						end
						idx_q   <= CW'(idx_q + 1'b1);
						state_q <= idx_end ? S_FIN : S_ORD;
					end else begin
						ent_q   <= ord_rdata;
						state_q <= S_DIF;
					end
				end
				S_DIF: begin
					done_q  <= 1'b0;
					state_q <= S_CMP;
				end
				S_CMP: begin
					// a fire releases the word held from the previous fire
					done_q <= valid_q[ent_q] && due && pend_q;
					if (valid_q[ent_q] && due) begin
						valid_q[ent_q] <= 1'b0;
						if (pend_q) begin
							status_q     <= ST_FIRED;
							slot_q       <= HANDLE_W'(IW'(pend_slot_q));
							out_target_q <= pend_target_q;
							out_tag_q    <= pend_tag_q;
							last_q       <= 1'b0;
						end
						pend_q        <= 1'b1;
						pend_slot_q   <= ent_q;
						pend_target_q <= slot_rdata.target;
						pend_tag_q    <= slot_rdata.tag;
					end else begin
						keep_q <= CW'(keep_q + 1'b1);
					end
					idx_q   <= CW'(idx_q + 1'b1);
					state_q <= idx_end ? S_FIN : S_ORD;
				end
				S_FIN: begin
					done_q  <= 1'b1;
					last_q  <= 1'b1;
					state_q <= S_IDLE;
					if (op_q == OP_CANCEL) begin
						slot_q       <= hdl_q;
						out_target_q <= '0;
						out_tag_q    <= '0;
						if (found_q) begin
							// a match implies the handle is a real slot
							valid_q[hdl_w[SW-1:0]] <= 1'b0;
							count_q                <= CW'(count_q - 1'b1);
							status_q               <= ST_CANCELLED;
						end else begin
							status_q <= ST_NOT_FOUND;
						end
					end else begin
						count_q <= keep_q;
						pend_q  <= 1'b0;
						if (pend_q) begin
							status_q     <= ST_FIRED;
							slot_q       <= HANDLE_W'(IW'(pend_slot_q));
							out_target_q <= pend_target_q;
							out_tag_q    <= pend_tag_q;
						end else begin
							status_q     <= ST_NOTHING_DUE;
							slot_q       <= '0;
							out_target_q <= '0;
							out_tag_q    <= '0;
						end
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign slot       = slot_q;
	assign out_target = out_target_q;
	assign out_tag    = out_tag_q;
	assign last       = last_q;

	assign count_ok = ($countones(valid_q) == int'(count_q));

	`TEL_ASSERT(a_count_range, count_q <= CW'(SLOTS), "order count above table size")
	`TEL_IMPLIES(a_idle_match, state_q == S_IDLE, count_ok, "valid bits disagree with order count")
	`TEL_IMPLIES(a_done_after_work, done_q, $past(busy), "result word without a command in flight")
	`TEL_IMPLIES(a_mid_word_busy, done_q && !last_q, busy, "non-final word after command ended")
	`TEL_NEXT(a_last_gap, done_q && last_q, !done_q, "word issued right after final word")

endmodule

// ----- test/timed_event_list_test.sv -----
// ----------------------------------------------------------------------------
// Timed event list testbench
// Drives request, cancel, process and ignored command words into the timer
// table, predicts every result word from a private copy of the table, and
// checks each done word field by field in arrival order.
// ----------------------------------------------------------------------------
module timed_event_list_test;
	import tel_pkg::*;

	localparam int NSLOT       = 16;
	localparam int RAND_WORDS  = 124;
	// worst correct wait between handshakes is a full process walk plus the
	// longest hold-off below; this is many times that
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 100;

	// one command word as driven on the input ports
	typedef struct {
		opcode_t             op;
		logic [TIME_W-1:0]   now;
		logic [TARGET_W-1:0] tgt;
		logic [TAG_W-1:0]    tag;
		logic [TIME_W-1:0]   dly;
		logic [HANDLE_W-1:0] handle;
	} timer_cmd_t;

	// one result word as it should appear while done is high
	typedef struct {
		status_t             st;
		logic [HANDLE_W-1:0] slot;
		logic [TARGET_W-1:0] tgt;
		logic [TAG_W-1:0]    tag;
		logic                last;
	} timer_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, all known from time zero
	logic                start = 1'b0;
	logic [1:0]          opcode = OP_NOP;
	logic [TIME_W-1:0]   now_ms = '0;
	logic [TARGET_W-1:0] target = '0;
	logic [TAG_W-1:0]    event_tag = '0;
	logic [TIME_W-1:0]   wait_ms = '0;
	logic [HANDLE_W-1:0] handle_slot = '0;

	logic                busy;
	logic                done;
	logic [2:0]          status;
	logic [HANDLE_W-1:0] slot;
	logic [TARGET_W-1:0] out_target;
	logic [TAG_W-1:0]    out_tag;
	logic                last;

	timed_event_list #(.SLOTS(NSLOT)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.now_ms     (now_ms),
		.target     (target),
		.event_tag  (event_tag),
		.wait_ms    (wait_ms),
		.handle_slot(handle_slot),
		.done       (done),
		.status     (status),
		.slot       (slot),
		.out_target (out_target),
		.out_tag    (out_tag),
		.last       (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow timer table
	// ------------------------------------------------------------------
	bit                  tbl_valid [NSLOT];
	logic [TARGET_W-1:0] tbl_target[NSLOT];
	logic [TAG_W-1:0]    tbl_tag   [NSLOT];
	logic [TIME_W-1:0]   tbl_start [NSLOT];
	logic [TIME_W-1:0]   tbl_wait  [NSLOT];
	int unsigned         live_order[$];     // pending slots, oldest first

	timer_reply_t reply_q[$];               // result words still owed by the block
	timer_cmd_t   cmd_q[$];                 // command words not yet driven
	timer_cmd_t   cur_cmd;
	timer_reply_t head_reply;

	int errors = 0;
	int words_sent = 0;
	int hold_off = 0;
	int stall_cycles = 0;
	int cmds_seen[4];
	int replies_seen = 0;
	int fired_seen = 0;
	logic cmd_taken = 1'b0;

	task automatic flag_mismatch(input string what);
		errors++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Apply one accepted command to the shadow table and queue its result words.
	task automatic timer_table_step(input timer_cmd_t c);
		int           free_idx;
		int           hit;
		int unsigned  s;
		int unsigned  kept[$];
		logic [TIME_W-1:0] elapsed;
		timer_reply_t r;
		timer_reply_t fire_q[$];
		r = '{st: ST_NOTHING_DUE, slot: '0, tgt: '0, tag: '0, last: 1'b1};
		case (c.op)
			OP_REQUEST: begin
				// lowest-numbered free slot wins
				free_idx = -1;
				for (int i = NSLOT - 1; i >= 0; i--)
					if (!tbl_valid[i]) free_idx = i;
				if (free_idx < 0) begin
					r.st = ST_FULL;
				end else begin
					tbl_valid[free_idx]  = 1'b1;
					tbl_target[free_idx] = c.tgt;
					tbl_tag[free_idx]    = c.tag;
					tbl_start[free_idx]  = c.now;
					tbl_wait[free_idx]   = c.dly;
					live_order.push_back(free_idx);
					r.st   = ST_QUEUED;
					r.slot = 4'(free_idx);
				end
				reply_q.push_back(r);
			end
			OP_CANCEL: begin
				hit = -1;
				foreach (live_order[k])
					if (hit < 0 && live_order[k] == c.handle) hit = k;
				r.slot = c.handle;
				if (hit >= 0) begin
					// later entries close the gap, keeping their order
					live_order.delete(hit);
					tbl_valid[c.handle] = 1'b0;
					r.st = ST_CANCELLED;
				end else begin
					r.st = ST_NOT_FOUND;
				end
				reply_q.push_back(r);
			end
			OP_PROCESS: begin
				foreach (live_order[k]) begin
					s = live_order[k];
					// elapsed time wraps mod 2^32, both sides compared as signed
					elapsed = c.now - tbl_start[s];
					if ($signed(elapsed) > $signed(tbl_wait[s])) begin
						r.st   = ST_FIRED;
						r.slot = 4'(s);
						r.tgt  = tbl_target[s];
						r.tag  = tbl_tag[s];
						r.last = 1'b0;
						fire_q.push_back(r);
						tbl_valid[s] = 1'b0;
					end else begin
						kept.push_back(s);
					end
				end
				live_order = kept;
				if (fire_q.size() == 0) begin
					reply_q.push_back(r);
				end else begin
					fire_q[fire_q.size() - 1].last = 1'b1;
					foreach (fire_q[k]) reply_q.push_back(fire_q[k]);
				end
			end
			default: ;  // opcode three is dropped, nothing owed
		endcase
	endtask

	function automatic timer_cmd_t mk_cmd(opcode_t op, logic [TIME_W-1:0] now,
			logic [TARGET_W-1:0] tgt, logic [TAG_W-1:0] tag, logic [TIME_W-1:0] dly,
			logic [HANDLE_W-1:0] handle);
		timer_cmd_t c;
		c.op     = op;
		c.now    = now;
		c.tgt    = tgt;
		c.tag    = tag;
		c.dly    = dly;
		c.handle = handle;
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Driver: new word on the falling edge once the previous one was taken.
	// The hold-off rolled with each word is spent after it is accepted, so
	// gaps land at varying points of the block's busy period; words 60..99
	// go back to back.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!start || cmd_taken)) begin
			if (hold_off > 0) begin
				start <= 1'b0;
				hold_off <= hold_off - 1;
			end else if (cmd_q.size() > 0) begin
				cur_cmd = cmd_q.pop_front();
				start       <= 1'b1;
				opcode      <= cur_cmd.op;
				now_ms      <= cur_cmd.now;
				target      <= cur_cmd.tgt;
				event_tag   <= cur_cmd.tag;
				wait_ms     <= cur_cmd.dly;
				handle_slot <= cur_cmd.handle;
				words_sent++;
				if ((words_sent >= 60 && words_sent < 100) || $urandom_range(0, 99) >= 32)
					hold_off <= 0;
				else if ($urandom_range(0, 3) == 0)
					hold_off <= $urandom_range(8, 40);
				else
					hold_off <= $urandom_range(1, 3);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: handshakes and result words sampled on the rising edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			cmd_taken <= start && !busy;

			// check first: a new command may be taken on the edge that
			// carries the previous command's final word
			if (done) begin
				replies_seen++;
				if (status == ST_FIRED) fired_seen++;
				if (reply_q.size() == 0) begin
					flag_mismatch($sformatf("word with nothing owed, status %0d slot %0d",
						status, slot));
				end else begin
					head_reply = reply_q.pop_front();
					if (status !== head_reply.st)
						flag_mismatch($sformatf("status got %0d want %0d",
							status, head_reply.st));
					if (slot !== head_reply.slot)
						flag_mismatch($sformatf("slot got %0d want %0d",
							slot, head_reply.slot));
					if (out_target !== head_reply.tgt)
						flag_mismatch($sformatf("out_target got %h want %h",
							out_target, head_reply.tgt));
					if (out_tag !== head_reply.tag)
						flag_mismatch($sformatf("out_tag got %h want %h",
							out_tag, head_reply.tag));
					if (last !== head_reply.last)
						flag_mismatch($sformatf("last got %b want %b",
							last, head_reply.last));
				end
			end

			if (start && !busy) begin
				cmds_seen[cur_cmd.op]++;
				timer_table_step(cur_cmd);
			end

			// watchdog on handshake-free cycles
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("status: fail");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		timer_cmd_t        c;
		logic [TIME_W-1:0] wall;
		logic [TIME_W-1:0] dly;
		int                pick;

		foreach (cmds_seen[k]) cmds_seen[k] = 0;

		// directed: empty table, unknown handles, dropped opcode
		cmd_q.push_back(mk_cmd(OP_PROCESS, 32'h0, 16'h0, 32'h0, 32'h0, 4'd0));
		cmd_q.push_back(mk_cmd(OP_CANCEL, 32'h0, 16'h0, 32'h0, 32'h0, 4'd0));
		cmd_q.push_back(mk_cmd(OP_CANCEL, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 4'd15));
		cmd_q.push_back(mk_cmd(OP_NOP, $urandom(), 16'($urandom()), $urandom(),
			$urandom(), 4'($urandom())));

		// fill every slot: field extremes, zero wait, -1 wait, largest and most
		// negative signed waits, start stamps at both ends of the time range
		cmd_q.push_back(mk_cmd(OP_REQUEST, 32'h0, 16'h0, 32'h0, 32'h0, 4'd0));
		cmd_q.push_back(mk_cmd(OP_REQUEST, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 4'd15));
		cmd_q.push_back(mk_cmd(OP_REQUEST, 32'd1000, 16'h1234, 32'h5555_AAAA,
			32'h7FFF_FFFF, 4'd0));
		cmd_q.push_back(mk_cmd(OP_REQUEST, 32'd1000, 16'hEDCB, 32'hAAAA_5555,
			32'h8000_0000, 4'd0));
		for (int i = 4; i < NSLOT; i++)
			cmd_q.push_back(mk_cmd(OP_REQUEST, 32'd1000 + i, 16'(i * 16'h1111),
				{16'(i), 16'($urandom())}, 32'(i * 100), 4'd0));

		// table full, then cancel from the middle and refill that slot
		cmd_q.push_back(mk_cmd(OP_REQUEST, 32'd1100, 16'hBEEF, 32'hCAFE_0001,
			32'd5, 4'd0));
		cmd_q.push_back(mk_cmd(OP_CANCEL, 32'd1100, 16'h0, 32'h0, 32'h0, 4'd7));
		cmd_q.push_back(mk_cmd(OP_CANCEL, 32'd1100, 16'h0, 32'h0, 32'h0, 4'd7));
		cmd_q.push_back(mk_cmd(OP_REQUEST, 32'd1200, 16'h0707, 32'h0707_0707,
			32'd0, 4'd0));

		// partial fire, then a far jump that wraps the signed difference
		cmd_q.push_back(mk_cmd(OP_PROCESS, 32'd1500, 16'h0, 32'h0, 32'h0, 4'd0));
		cmd_q.push_back(mk_cmd(OP_PROCESS, 32'h9000_0000, 16'h0, 32'h0, 32'h0, 4'd0));

		// random: mostly short waits on a slowly advancing clock so timers fire,
		// with occasional full-range waits and clock jumps
		wall = 32'd2000;
		for (int n = 0; n < RAND_WORDS; n++) begin
			if ($urandom_range(0, 99) < 3)
				wall = $urandom();
			else
				wall = wall + $urandom_range(0, 150);
			case ($urandom_range(0, 19)) inside
				0, 1:    dly = $urandom();
				2:       dly = 32'h8000_0000;
				3:       dly = 32'h7FFF_FFFF;
				default: dly = $urandom_range(0, 400);
			endcase
			pick = $urandom_range(0, 99);
			c = mk_cmd(OP_NOP, wall, 16'($urandom()), $urandom(), dly,
				4'($urandom_range(0, NSLOT - 1)));
			if (pick < 40)      c.op = OP_REQUEST;
			else if (pick < 60) c.op = OP_CANCEL;
			else if (pick < 96) c.op = OP_PROCESS;
			cmd_q.push_back(c);
		end

		// single reset at the start of the run
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all words taken and all results in, then let the block settle
		while (cmd_q.size() > 0 || start || reply_q.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (reply_q.size() > 0)
			flag_mismatch($sformatf("%0d result words never arrived", reply_q.size()));

		$display("commands: %0d request, %0d cancel, %0d process, %0d dropped",
			cmds_seen[OP_REQUEST], cmds_seen[OP_CANCEL], cmds_seen[OP_PROCESS],
			cmds_seen[OP_NOP]);
		$display("result words checked: %0d (%0d fired timers), mismatches: %0d",
			replies_seen, fired_seen, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
